### rtl/gfalu_pkg.sv
// Shared types, operation codes and GF(2^8) helper functions for the GF(2^16) arithmetic unit.
`timescale 1ns / 1ps

package gfalu_pkg;

    // Operation codes carried in the func field.
    typedef enum logic [1:0] {
        FUNC_MUL = 2'd0,
        FUNC_DIV = 2'd1,
        FUNC_INV = 2'd2,
        FUNC_POW = 2'd3
    } func_t;

    // x^-1 = x^(2^16 - 2) in the multiplicative group of order 65535.
    localparam logic [15:0] INV_EXP = 16'hFFFE;

    // The tail coefficient of z^2 + z + 32 is 32 = x^5 in GF(2^8).
    localparam int TAIL_SHIFTS = 5;

    // Multiply a GF(2^8) element by x, reducing with the low byte of the polynomial.
    function automatic logic [7:0] gf_xtime(input logic [7:0] v, input logic [7:0] red);
        gf_xtime = {v[6:0], 1'b0} ^ (v[7] ? red : 8'h00);
    endfunction

    // Multiply a GF(2^8) element by the tail coefficient 32.
    function automatic logic [7:0] gf_mul_tail(input logic [7:0] v, input logic [7:0] red);
        logic [7:0] t;
        t = v;
        for (int i = 0; i < TAIL_SHIFTS; i++)
        begin
            t = gf_xtime(t, red);
        end
        gf_mul_tail = t;
    endfunction

endpackage

### rtl/gf65536_composite_field_alu_core.sv
// Top level of the GF(2^16) composite-field arithmetic unit with a bit-serial multiplier.
`timescale 1ns / 1ps

// This block performs multiply, divide, inverse and power in GF(2^16), built as
// GF(2^8)[z]/(z^2 + z + 32), where the GF(2^8) reduction polynomial is held in a
// configuration register (reset 0x11D; bit 8 is always taken as set). All work runs on
// one shared field multiplier that consumes one bit of each byte of its second operand
// per cycle; a field multiply is 8 shift steps plus one step to combine the partial
// bytes. Inverse and power use square-and-multiply over a 16-bit exponent: 16 squarings
// plus one multiply for every set exponent bit. A divide adds one final multiply by the
// dividend. Divide by zero and inverse of zero skip the arithmetic and return a zero
// result with no_answer set. One item is worked on at a time; a new input beat is
// taken as soon as the unit is idle, even while the previous result beat still waits
// in the output register. Configuration writes are always ready and must only be
// issued while the unit is idle.
module gf65536_composite_field_alu_core
    import gfalu_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    // Configuration write channel: GF(2^8) reduction polynomial.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,

    // Input beats. s_tdata fields from bit 0 up: func[1:0], operand_a[17:2],
    // operand_b[33:18], exponent[50:34], zero fill[55:51].
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,

    // Result beats. m_tdata fields from bit 0 up: result[15:0], no_answer[16],
    // zero fill[23:17].
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } state_t;

    // What the multiply in flight stands for.
    typedef enum logic [1:0] {
        KIND_SQ,
        KIND_MULB,
        KIND_FINAL,
        KIND_FLAG
    } kind_t;

    state_t      state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [2:0]  step_reg, step_next;
    logic [3:0]  cnt_reg, cnt_next;
    func_t       func_reg, func_next;
    logic [7:0]  poly_reg, poly_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0] mx_reg, mx_next;
    logic [15:0] my_reg, my_next;
    logic [7:0]  hh_reg, hh_next;
    logic [7:0]  hl_reg, hl_next;
    logic [7:0]  lh_reg, lh_next;
    logic [7:0]  ll_reg, ll_next;
    logic [15:0] base_reg, base_next;
    logic [15:0] akeep_reg, akeep_next;
    logic [15:0] e_reg, e_next;
    logic [15:0] out_result_reg, out_result_next;
    logic        out_flag_reg, out_flag_next;

    // Input field views.
    func_t       in_func;
    logic [15:0] in_a;
    logic [15:0] in_b;
    logic [16:0] in_e;
    logic [15:0] pow_exp;

    logic [15:0] product;
    logic        out_free;

    logic        start_req;
    logic [15:0] start_x;
    logic [15:0] start_y;
    kind_t       start_kind;

    assign in_func = func_t'(s_tdata[1:0]);
    assign in_a    = s_tdata[17:2];
    assign in_b    = s_tdata[33:18];
    assign in_e    = s_tdata[50:34];

    // Exponents that are zero or negative get the group order added; the lowest
    // 17-bit code wraps once more and lands on 65534.
    always_comb
    begin
        if (in_e == 17'h10000)
        begin
            pow_exp = INV_EXP;
        end
        else if (in_e[16] || (in_e == 17'h00000))
        begin
            pow_exp = in_e[15:0] - 16'd1;
        end
        else
        begin
            pow_exp = in_e[15:0];
        end
    end

    // Combine the four byte products: hi = hl + lh + hh, lo = ll + 32 * hh.
    assign product = {hl_reg ^ lh_reg ^ hh_reg, ll_reg ^ gf_mul_tail(hh_reg, poly_reg)};

    assign out_free  = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {7'd0, out_flag_reg, out_result_reg};

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        step_next       = step_reg;
        cnt_next        = cnt_reg;
        func_next       = func_reg;
        poly_next       = poly_reg;
        out_valid_next  = out_valid_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        hh_next         = hh_reg;
        hl_next         = hl_reg;
        lh_next         = lh_reg;
        ll_next         = ll_reg;
        base_next       = base_reg;
        akeep_next      = akeep_reg;
        e_next          = e_reg;
        out_result_next = out_result_reg;
        out_flag_next   = out_flag_reg;
        start_req       = 1'b0;
        start_x         = product;
        start_y         = product;
        start_kind      = KIND_SQ;

        if (cfg_valid)
        begin
            poly_next = cfg_data[7:0];
        end

        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    func_next  = in_func;
                    akeep_next = in_a;
                    cnt_next   = 4'd15;
                    unique case (in_func)
                        FUNC_MUL:
                        begin
                            start_req  = 1'b1;
                            start_x    = in_a;
                            start_y    = in_b;
                            start_kind = KIND_FINAL;
                        end
                        FUNC_DIV:
                        begin
                            if (in_b == 16'd0)
                            begin
                                kind_next  = KIND_FLAG;
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                base_next  = in_b;
                                e_next     = INV_EXP;
                                start_req  = 1'b1;
                                start_x    = 16'd1;
                                start_y    = 16'd1;
                                start_kind = KIND_SQ;
                            end
                        end
                        FUNC_INV:
                        begin
                            if (in_a == 16'd0)
                            begin
                                kind_next  = KIND_FLAG;
                                state_next = ST_FIN;
                            end
                            else
                            begin
                                base_next  = in_a;
                                e_next     = INV_EXP;
                                start_req  = 1'b1;
                                start_x    = 16'd1;
                                start_y    = 16'd1;
                                start_kind = KIND_SQ;
                            end
                        end
                        FUNC_POW:
                        begin
                            base_next  = in_a;
                            e_next     = pow_exp;
                            start_req  = 1'b1;
                            start_x    = 16'd1;
                            start_y    = 16'd1;
                            start_kind = KIND_SQ;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                // Horner step, most significant multiplier bit first.
                hh_next   = gf_xtime(hh_reg, poly_reg) ^ (my_reg[15] ? mx_reg[15:8] : 8'h00);
                hl_next   = gf_xtime(hl_reg, poly_reg) ^ (my_reg[7]  ? mx_reg[15:8] : 8'h00);
                lh_next   = gf_xtime(lh_reg, poly_reg) ^ (my_reg[15] ? mx_reg[7:0]  : 8'h00);
                ll_next   = gf_xtime(ll_reg, poly_reg) ^ (my_reg[7]  ? mx_reg[7:0]  : 8'h00);
                my_next   = {my_reg[14:0], 1'b0};
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd7)
                begin
                    state_next = ST_FIN;
                end
            end

            ST_FIN:
            begin
                unique case (kind_reg)
                    KIND_SQ, KIND_MULB:
                    begin
                        if ((kind_reg == KIND_SQ) && e_reg[15])
                        begin
                            start_req  = 1'b1;
                            start_x    = product;
                            start_y    = base_reg;
                            start_kind = KIND_MULB;
                        end
                        else if (cnt_reg != 4'd0)
                        begin
                            cnt_next   = cnt_reg - 4'd1;
                            e_next     = {e_reg[14:0], 1'b0};
                            start_req  = 1'b1;
                            start_kind = KIND_SQ;
                        end
                        else if (func_reg == FUNC_DIV)
                        begin
                            start_req  = 1'b1;
                            start_x    = product;
                            start_y    = akeep_reg;
                            start_kind = KIND_FINAL;
                        end
                        else if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_result_next = product;
                            out_flag_next   = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    KIND_FINAL:
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_result_next = product;
                            out_flag_next   = 1'b0;
                            state_next      = ST_IDLE;
                        end
                    end
                    KIND_FLAG:
                    begin
                        if (out_free)
                        begin
                            out_valid_next  = 1'b1;
                            out_result_next = 16'd0;
                            out_flag_next   = 1'b1;
                            state_next      = ST_IDLE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Load the shared multiplier with a fresh operand pair.
        if (start_req)
        begin
            mx_next    = start_x;
            my_next    = start_y;
            hh_next    = 8'h00;
            hl_next    = 8'h00;
            lh_next    = 8'h00;
            ll_next    = 8'h00;
            step_next  = 3'd0;
            kind_next  = start_kind;
            state_next = ST_RUN;
        end
    end

    // Control state and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_FINAL;
            step_reg      <= 3'd0;
            cnt_reg       <= 4'd0;
            func_reg      <= FUNC_MUL;
            poly_reg      <= 8'h1D;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            step_reg      <= step_next;
            cnt_reg       <= cnt_next;
            func_reg      <= func_next;
            poly_reg      <= poly_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers; their contents only matter under the control state above.
    always_ff @(posedge clk)
    begin
        mx_reg         <= mx_next;
        my_reg         <= my_next;
        hh_reg         <= hh_next;
        hl_reg         <= hl_next;
        lh_reg         <= lh_next;
        ll_reg         <= ll_next;
        base_reg       <= base_next;
        akeep_reg      <= akeep_next;
        e_reg          <= e_next;
        out_result_reg <= out_result_next;
        out_flag_reg   <= out_flag_next;
    end

endmodule

### bench/tb_top.sv
// Self-checking testbench for the GF(2^16) composite-field arithmetic unit.
`timescale 1ns / 1ps

// The bench drives operation beats into the unit and checks every result beat against a
// predictor of GF(2^16) = GF(2^8)[z]/(z^2 + z + 32) kept in this file.
//
// Flow:
//   - A short directed table runs first at the reset polynomial. It covers the field
//     extremes, all four operations, divide and inverse by zero, zero and negative
//     exponents, the out-of-range exponent -65536, and operands that an operation ignores.
//     Rows whose answer is obvious (identity, zero, z*z = z + 32) carry a typed-in
//     expectation. All other rows go through the predictor.
//   - Random phases follow: one more at the reset polynomial, then one for each written
//     base-field polynomial. Among them are the extremes 0x1FF and 0x101, and a value
//     with bit 8 clear, which the unit must treat as if bit 8 were set.
//   - The polynomial is only rewritten once the unit has drained and is idle.
//   - Both sides insert random gaps: mostly short, a few long, and one phase runs with
//     no gaps at all. Early on, the result side holds off for a long stretch so the unit
//     backs up and stalls its input.
// Drivers change at the falling edge and the handshakes are sampled at the rising edge.
module tb_top;
    import gfalu_pkg::*;

    localparam logic [8:0]  RESET_POLY       = 9'h11D;
    localparam logic [7:0]  TAIL_COEF        = 8'd32;
    localparam int          GROUP_ORDER      = 65535;
    localparam logic [15:0] INVERSE_EXP      = 16'hFFFE;
    localparam int          LONG_HOLD_CYCLES = 1000;
    // Longer than the slowest item, so this covers the tail of any run.
    localparam int          DRAIN_CYCLES     = 320;
    localparam int          FIRST_RANDOM     = 140;
    localparam int          PHASE_RANDOM     = 110;
    localparam int          NUM_POLYS        = 4;

    // One operation beat, packed so that func lands in the lowest bits of s_tdata.
    typedef struct packed {
        logic [16:0] exponent;
        logic [15:0] operand_b;
        logic [15:0] operand_a;
        func_t       func;
    } op_beat_t;

    typedef struct {
        logic [15:0] value;
        logic        no_answer;
    } answer_t;

    typedef struct {
        op_beat_t beat;
        bit       typed;
        answer_t  want;
    } op_case_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [8:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [55:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;

    // Predictor state: the polynomial the unit currently holds.
    logic [8:0]  poly_now;
    answer_t     answers_due[$];
    op_case_t    directed_cases[$];

    bit          gaps_enabled;
    bit          hold_request;
    int          fail_count;
    int          beats_checked;
    int          polys_used;
    int          ops_sent[4];

    logic [8:0]  poly_list[NUM_POLYS] = '{9'h1FF, 9'h101, 9'h02B, 9'h11D};

    gf65536_composite_field_alu_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // func[1:0], operand_a[17:2], operand_b[33:18], exponent[50:34]
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)    // result[15:0], no_answer[16]
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------------------------------------------------------- predictor

    // Shift-and-add product in GF(2^8). Only the low byte of the polynomial reduces.
    function automatic logic [7:0] gf8_mul(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] red);
        logic [7:0] acc;
        logic [7:0] x;
        int         i;
        acc = 8'h00;
        x = a;
        for (i = 0; i < 8; i++)
        begin
            if (b[i])
                acc ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? red : 8'h00);
        end
        return acc;
    endfunction

    // (xh*z + xl)(yh*z + yl) with z^2 = z + 32.
    function automatic logic [15:0] gf16_mul(input logic [15:0] x, input logic [15:0] y,
                                             input logic [7:0] red);
        logic [7:0] hh;
        logic [7:0] hi;
        logic [7:0] lo;
        hh = gf8_mul(x[15:8], y[15:8], red);
        hi = gf8_mul(x[15:8], y[7:0], red) ^ gf8_mul(x[7:0], y[15:8], red) ^ hh;
        lo = gf8_mul(x[7:0], y[7:0], red) ^ gf8_mul(TAIL_COEF, hh, red);
        return {hi, lo};
    endfunction

    // Left-to-right square-and-multiply over all 16 exponent bits; x^0 = 1 even for x = 0.
    function automatic logic [15:0] gf16_pow(input logic [15:0] x, input logic [15:0] e,
                                             input logic [7:0] red);
        logic [15:0] acc;
        int          i;
        acc = 16'h0001;
        for (i = 15; i >= 0; i--)
        begin
            acc = gf16_mul(acc, acc, red);
            if (e[i])
                acc = gf16_mul(acc, x, red);
        end
        return acc;
    endfunction

    function automatic answer_t gf_alu_answer(input op_beat_t beat, input logic [8:0] poly);
        answer_t ans;
        int      ex;
        ans.value = 16'h0000;
        ans.no_answer = 1'b0;
        case (beat.func)
            FUNC_MUL:
                ans.value = gf16_mul(beat.operand_a, beat.operand_b, poly[7:0]);
            FUNC_DIV:
                if (beat.operand_b == 16'h0000)
                    ans.no_answer = 1'b1;
                else
                    ans.value = gf16_mul(beat.operand_a,
                                         gf16_pow(beat.operand_b, INVERSE_EXP, poly[7:0]),
                                         poly[7:0]);
            FUNC_INV:
                if (beat.operand_a == 16'h0000)
                    ans.no_answer = 1'b1;
                else
                    ans.value = gf16_pow(beat.operand_a, INVERSE_EXP, poly[7:0]);
            default:
            begin
                // Zero and negative exponents are lifted by the group order; -65536 needs
                // a second lift and ends up at 65534.
                ex = $signed(beat.exponent);
                if (ex <= 0)
                    ex += GROUP_ORDER;
                if (ex < 0)
                    ex += GROUP_ORDER;
                ans.value = gf16_pow(beat.operand_a, ex[15:0], poly[7:0]);
            end
        endcase
        return ans;
    endfunction

    // ---------------------------------------------------------------- stimulus helpers

    function automatic int pick_gap();
        int r;
        if (!gaps_enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 45);
    endfunction

    function automatic logic [15:0] pick_operand();
        case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'hFFFF;
            3: return 16'h0001 << $urandom_range(0, 15);
            4: return {8'h00, 8'($urandom_range(0, 255))};
            5: return {8'($urandom_range(0, 255)), 8'h00};
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic op_beat_t random_beat();
        op_beat_t beat;
        beat.func = func_t'($urandom_range(0, 3));
        beat.operand_a = pick_operand();
        beat.operand_b = pick_operand();
        case ($urandom_range(0, 5))
            0: beat.exponent = 17'($urandom_range(0, 20));
            1: beat.exponent = 17'h1FFFF - 17'($urandom_range(0, 20));
            2:
            begin
                case ($urandom_range(0, 3))
                    0: beat.exponent = 17'h0FFFF;
                    1: beat.exponent = 17'h10001;
                    2: beat.exponent = 17'h10000;
                    default: beat.exponent = 17'h0FFFE;
                endcase
            end
            default: beat.exponent = 17'($urandom_range(0, 17'h1FFFF));
        endcase
        return beat;
    endfunction

    function automatic void add_case(input func_t func, input logic [15:0] a,
                                     input logic [15:0] b, input int e, input bit typed,
                                     input logic [15:0] want, input logic want_flag);
        op_case_t c;
        c.beat.func = func;
        c.beat.operand_a = a;
        c.beat.operand_b = b;
        c.beat.exponent = 17'(e);
        c.typed = typed;
        c.want.value = want;
        c.want.no_answer = want_flag;
        directed_cases.push_back(c);
    endfunction

    // Offer one beat after a random gap and hold it until the unit takes it. The
    // expectation is queued at the accepting edge, with the polynomial in force then.
    task automatic offer_operation(input op_beat_t beat, input bit typed,
                                   input answer_t typed_answer);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, beat};
        do
            @(posedge clk);
        while (!s_tready);
        answers_due.push_back(typed ? typed_answer : gf_alu_answer(beat, poly_now));
        ops_sent[beat.func]++;
    endtask

    // Lower valid and wait until every expected result beat has been seen.
    task automatic drain_unit();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_poly(input logic [8:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        poly_now = value;
        polys_used++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // ---------------------------------------------------------------- main sequence

    initial
    begin : stimulus
        answer_t none;
        int      p;
        none.value = 16'h0000;
        none.no_answer = 1'b0;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_data     = 9'h000;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        gaps_enabled = 1'b1;
        hold_request = 1'b0;
        fail_count   = 0;
        polys_used   = 1;
        poly_now     = RESET_POLY;

        // Directed rows. A typed-in answer is given only where it is obvious.
        add_case(FUNC_MUL, 16'h0000, 16'h0000, 0, 1, 16'h0000, 1'b0);
        add_case(FUNC_MUL, 16'h0001, 16'hFFFF, 0, 1, 16'hFFFF, 1'b0);
        add_case(FUNC_MUL, 16'hFFFF, 16'hFFFF, 0, 0, 16'h0000, 1'b0);
        add_case(FUNC_MUL, 16'h0100, 16'h0100, 0, 1, 16'h0120, 1'b0);
        add_case(FUNC_MUL, 16'h8001, 16'h00FF, -65536, 0, 16'h0000, 1'b0);
        add_case(FUNC_DIV, 16'h1234, 16'h0000, 0, 1, 16'h0000, 1'b1);
        add_case(FUNC_DIV, 16'h0000, 16'h0000, 0, 1, 16'h0000, 1'b1);
        add_case(FUNC_DIV, 16'h0000, 16'hFFFF, 0, 1, 16'h0000, 1'b0);
        add_case(FUNC_DIV, 16'hFFFF, 16'h0001, 0, 1, 16'hFFFF, 1'b0);
        add_case(FUNC_DIV, 16'hFFFF, 16'hFFFF, 65535, 0, 16'h0000, 1'b0);
        add_case(FUNC_DIV, 16'h0001, 16'h8000, 0, 0, 16'h0000, 1'b0);
        add_case(FUNC_INV, 16'h0000, 16'hFFFF, 0, 1, 16'h0000, 1'b1);
        add_case(FUNC_INV, 16'h0001, 16'h0000, 0, 1, 16'h0001, 1'b0);
        add_case(FUNC_INV, 16'hFFFF, 16'h0000, 0, 0, 16'h0000, 1'b0);
        add_case(FUNC_INV, 16'h8000, 16'h5A5A, -1, 0, 16'h0000, 1'b0);
        add_case(FUNC_POW, 16'h0000, 16'h0000, 0, 1, 16'h0000, 1'b0);
        add_case(FUNC_POW, 16'h1234, 16'h0000, 1, 1, 16'h1234, 1'b0);
        add_case(FUNC_POW, 16'h0100, 16'h0000, 2, 1, 16'h0120, 1'b0);
        add_case(FUNC_POW, 16'h0005, 16'h0000, 65535, 0, 16'h0000, 1'b0);
        add_case(FUNC_POW, 16'hFFFF, 16'h0000, -65535, 1, 16'h0001, 1'b0);
        add_case(FUNC_POW, 16'h0000, 16'h0000, -65535, 1, 16'h0001, 1'b0);
        add_case(FUNC_POW, 16'hABCD, 16'h0000, -65536, 0, 16'h0000, 1'b0);
        add_case(FUNC_POW, 16'hABCD, 16'h0000, -1, 0, 16'h0000, 1'b0);
        add_case(FUNC_POW, 16'h0203, 16'hFFFF, 65534, 0, 16'h0000, 1'b0);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // The first phase runs at the reset polynomial.
        foreach (directed_cases[i])
            offer_operation(directed_cases[i].beat, directed_cases[i].typed,
                            directed_cases[i].want);

        // Back the unit up: results stall for a long stretch while beats keep coming.
        hold_request = 1'b1;
        repeat (FIRST_RANDOM) offer_operation(random_beat(), 1'b0, none);

        for (p = 0; p < NUM_POLYS; p++)
        begin
            drain_unit();
            write_poly(poly_list[p]);
            // One phase runs with back-to-back beats and no result stalls.
            gaps_enabled = (p != 1);
            repeat (PHASE_RANDOM) offer_operation(random_beat(), 1'b0, none);
        end

        drain_unit();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d operation beats (mul %0d, div %0d, inv %0d, pow %0d) under %0d polynomials.",
                 ops_sent[0] + ops_sent[1] + ops_sent[2] + ops_sent[3],
                 ops_sent[0], ops_sent[1], ops_sent[2], ops_sent[3], polys_used);
        $display("Checked %0d result beats, %0d errors.", beats_checked, fail_count);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------- result side

    // Ready pattern for result beats. A hold request forces a long stall, counted here.
    initial
    begin : result_ready
        int stall_left;
        int r;
        m_tready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (gaps_enabled)
                begin
                    r = $urandom_range(0, 99);
                    if (r < 3)
                        stall_left = $urandom_range(10, 45);
                    else if (r < 25)
                        stall_left = $urandom_range(1, 3);
                end
            end
        end
    end

    // Compare each accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : check_results
        answer_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            beats_checked++;
            if (answers_due.size() == 0)
            begin
                $error("unexpected result beat: m_tdata = %h", m_tdata);
                fail_count++;
            end
            else
            begin
                want = answers_due.pop_front();
                if (m_tdata[15:0] !== want.value)
                begin
                    $error("result: expected %h, got %h", want.value, m_tdata[15:0]);
                    fail_count++;
                end
                if (m_tdata[16] !== want.no_answer)
                begin
                    $error("no_answer: expected %b, got %b", want.no_answer, m_tdata[16]);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog, far beyond the slowest correct run.
    initial
    begin : watchdog
        #10_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
